>>> rtl/core/pts_pkg.sv
// shared constants, types and constant tables for the sstv tone synthesizer
`timescale 1ns / 1ps

package pts_pkg;

  localparam int SINE_TABLE_BITS = 10;
  localparam int QTAB_BITS       = SINE_TABLE_BITS - 2;
  localparam int QTAB_SIZE       = 1 << QTAB_BITS;

  localparam int PHASE_W   = 32;
  localparam int SAMPLE_W  = 16;
  localparam int AMP_W     = 15;
  localparam int HZ_W      = 28;
  localparam int CNT_W     = 12;
  localparam int FREQ_W    = 12;
  localparam int PROD_W    = HZ_W + FREQ_W;
  localparam int STEP_FRAC = 8;
  localparam int PIX_W     = 8;
  localparam int PIX_N     = 1 << PIX_W;
  localparam int ITER_W    = $clog2(FREQ_W + 1);
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_HZ_TO_STEP    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_SAMPLES = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SAMPLES  = CFG_IDX_W'(2);

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  localparam logic [HZ_W-1:0]  HZ_TO_STEP_RST    = HZ_W'(22906492);
  localparam logic [CNT_W-1:0] PIXEL_SAMPLES_RST = CNT_W'(22);
  localparam logic [CNT_W-1:0] SYNC_SAMPLES_RST  = CNT_W'(240);

  localparam logic [FREQ_W-1:0] SYNC_FREQ = FREQ_W'(1200);

  typedef logic [QTAB_SIZE-1:0][AMP_W-1:0] sine_tab_t;
  typedef logic [PIX_N-1:0][FREQ_W-1:0]    freq_tab_t;

  // one quarter-wave entry from a truncated taylor sum in q30
  function automatic logic [AMP_W-1:0] quarter_entry(input int unsigned k);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] s;
    logic [63:0]        r;
    x    = (64'd3373259426 * (64'(2 * k) + 64'd1)) >> SINE_TABLE_BITS;
    x2   = (x * x) >> 30;
    term = x;
    s    = signed'(x);
    term = ((term * x2) >> 30) / 64'd6;
    s    = s - signed'(term);
    term = ((term * x2) >> 30) / 64'd20;
    s    = s + signed'(term);
    term = ((term * x2) >> 30) / 64'd42;
    s    = s - signed'(term);
    term = ((term * x2) >> 30) / 64'd72;
    s    = s + signed'(term);
    term = ((term * x2) >> 30) / 64'd110;
    s    = s - signed'(term);
    term = ((term * x2) >> 30) / 64'd156;
    s    = s + signed'(term);
    term = ((term * x2) >> 30) / 64'd210;
    s    = s - signed'(term);
    term = ((term * x2) >> 30) / 64'd272;
    s    = s + signed'(term);
    if (s < 0) begin
      s = 0;
    end
    if (s > 64'sd1073741824) begin
      s = 64'sd1073741824;
    end
    r = (unsigned'(s) * 64'd25000 + 64'd536870912) >> 30;
    return r[AMP_W-1:0];
  endfunction

  function automatic sine_tab_t build_sine_tab();
    sine_tab_t t;
    for (int k = 0; k < QTAB_SIZE; k++) begin
      t[k] = quarter_entry(k);
    end
    return t;
  endfunction

  // pixel tone: 1500 + floor(800 * p / 255) hz
  function automatic freq_tab_t build_freq_tab();
    freq_tab_t t;
    for (int p = 0; p < PIX_N; p++) begin
      t[p] = FREQ_W'(1500 + (800 * p) / 255);
    end
    return t;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();
  localparam freq_tab_t FREQ_TAB = build_freq_tab();

endpackage

>>> rtl/core/pts_mul.sv
// iterative shift-add multiplier for tone frequency times phase step per hertz
`timescale 1ns / 1ps

module pts_mul import pts_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [HZ_W-1:0]   mcand,
  input  logic [FREQ_W-1:0] mplier,
  output logic              done,
  output logic [PROD_W-1:0] prod
);

  logic [PROD_W-1:0] p_r, p_nxt;
  logic [HZ_W-1:0]   mc_r;
  logic [ITER_W-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [HZ_W:0]     sum;

  assign sum = {1'b0, p_r[PROD_W-1:FREQ_W]} + {1'b0, (p_r[0] ? mc_r : HZ_W'(0))};

  always_comb begin
    p_nxt    = p_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      p_nxt    = {HZ_W'(0), mplier};
      cnt_nxt  = ITER_W'(FREQ_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      p_nxt   = {sum, p_r[FREQ_W-1:1]};
      cnt_nxt = cnt_r - ITER_W'(1);
      if (cnt_r == ITER_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
    if (start) begin
      mc_r <= mcand;
    end
  end

  assign done = done_r;
  assign prod = p_r;

endmodule

>>> rtl/core/pts_sine.sv
// quarter-wave sine lookup from the phase accumulator
`timescale 1ns / 1ps

module pts_sine import pts_pkg::*; (
  input  logic [PHASE_W-1:0]       phase,
  output logic signed [SAMPLE_W-1:0] sample
);

  logic [1:0]           quad;
  logic [QTAB_BITS-1:0] k;
  logic [QTAB_BITS-1:0] j;
  logic [AMP_W-1:0]     v;
  logic [SAMPLE_W-1:0]  v_ext;

  assign quad  = phase[PHASE_W-1 -: 2];
  assign k     = phase[PHASE_W-3 -: QTAB_BITS];
  // mirrored quadrants read the table backwards
  assign j     = quad[0] ? ~k : k;
  assign v     = SINE_TAB[j];
  assign v_ext = SAMPLE_W'(v);
  assign sample = quad[1] ? signed'(-v_ext) : signed'(v_ext);

endmodule

>>> rtl/core/sstv_pixel_tone_synth.sv
// top level of the sstv pixel tone synthesizer
`timescale 1ns / 1ps

// sstv tone synthesizer: every input beat gives exactly one output beat.
// input beat: in_req_type selects a symbol load or a sample tick. a load
// takes in_is_sync and in_pixel_value, sets the sample count at once and
// computes the new phase step in a shift-add multiplier, 12 iterations, so
// a load holds in_stall until the multiplier is done. a tick with samples
// left reads the sine table at the current phase and advances it.
// output beat: registered, shown in the cycle after the input beat. a load or
// a tick with no samples left gives out_sample_valid low and a zero sample.
// out_last_sample marks the final sample of a symbol.
// out_stall holds the output register; the block raises in_stall while the
// output register is full and stalled.
// configuration: cfg_ready is always high; index 0 hz_to_step, 1 pixel
// samples, 2 sync samples, others ignored. write only while idle.
// reset (rst_n low, synchronous) zeroes phase, step and sample count and
// loads the register defaults.
module sstv_pixel_tone_synth import pts_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_req_type,
  input  logic [PIX_W-1:0]           in_pixel_value,
  input  logic                       in_is_sync,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] out_sample,
  output logic                       out_sample_valid,
  output logic                       out_last_sample,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [HZ_W-1:0]            cfg_data
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_MUL  = 1'b1;

  logic                       state_r, state_nxt;
  logic [HZ_W-1:0]            hz_r;
  logic [CNT_W-1:0]           pix_cnt_r;
  logic [CNT_W-1:0]           sync_cnt_r;
  logic [PHASE_W-1:0]         phase_r, phase_nxt;
  logic [PHASE_W-1:0]         step_r, step_nxt;
  logic [CNT_W-1:0]           left_r, left_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0] out_sample_r, out_sample_nxt;
  logic                       out_sv_r, out_sv_nxt;
  logic                       out_last_r, out_last_nxt;
  logic                       in_acc;
  logic                       tick_act;
  logic                       mul_start;
  logic                       mul_done;
  logic [FREQ_W-1:0]          freq;
  logic [PROD_W-1:0]          mul_prod;
  logic signed [SAMPLE_W-1:0] sine_val;

  assign in_stall  = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign in_acc    = in_valid && !in_stall;
  assign mul_start = in_acc && (in_req_type == REQ_LOAD);
  assign tick_act  = (in_req_type == REQ_TICK) && (left_r != '0);
  assign freq      = in_is_sync ? SYNC_FREQ : FREQ_TAB[in_pixel_value];
  assign cfg_ready = 1'b1;

  pts_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .mcand  (hz_r),
    .mplier (freq),
    .done   (mul_done),
    .prod   (mul_prod)
  );

  pts_sine u_sine (
    .phase  (phase_r),
    .sample (sine_val)
  );

  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    step_nxt       = step_r;
    left_nxt       = left_r;
    out_valid_nxt  = out_valid_r;
    out_sample_nxt = out_sample_r;
    out_sv_nxt     = out_sv_r;
    out_last_nxt   = out_last_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          out_valid_nxt  = 1'b1;
          out_sample_nxt = '0;
          out_sv_nxt     = 1'b0;
          out_last_nxt   = 1'b0;
          if (in_req_type == REQ_LOAD) begin
            left_nxt  = in_is_sync ? sync_cnt_r : pix_cnt_r;
            state_nxt = ST_MUL;
          end else if (tick_act) begin
            out_sample_nxt = sine_val;
            out_sv_nxt     = 1'b1;
            out_last_nxt   = (left_r == CNT_W'(1));
            phase_nxt      = phase_r + step_r;
            left_nxt       = left_r - CNT_W'(1);
          end
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          step_nxt  = mul_prod[STEP_FRAC +: PHASE_W];
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= '0;
      step_r      <= '0;
      left_r      <= '0;
      out_valid_r <= 1'b0;
      hz_r        <= HZ_TO_STEP_RST;
      pix_cnt_r   <= PIXEL_SAMPLES_RST;
      sync_cnt_r  <= SYNC_SAMPLES_RST;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      step_r      <= step_nxt;
      left_r      <= left_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_HZ_TO_STEP:    hz_r       <= cfg_data;
          CFG_PIXEL_SAMPLES: pix_cnt_r  <= cfg_data[CNT_W-1:0];
          CFG_SYNC_SAMPLES:  sync_cnt_r <= cfg_data[CNT_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_sample_r <= out_sample_nxt;
    out_sv_r     <= out_sv_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_sample       = out_sample_r;
  assign out_sample_valid = out_sv_r;
  assign out_last_sample  = out_last_r;

endmodule
